FILE: hw/rtl/ethernet_arp_ipv4_header_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet / ARP / IPv4 header parser
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_ARP_IPV4_HEADER_PARSER_MACROS_SVH
`define ETHERNET_ARP_IPV4_HEADER_PARSER_MACROS_SVH

// check a property on every rising edge outside reset
`define EAIP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("eaip assertion failed");

// check that a condition in one cycle implies another in the next
`define EAIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eaip assertion failed");

`endif

FILE: hw/rtl/eaip_pkg.sv
// ----------------------------------------------------------------------------
// eaip_pkg
// Types and constants shared by the header parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eaip_pkg;

  localparam logic [6:0]  OFF_MAX   = 7'd127;
  localparam logic [6:0]  IP_BASE   = 7'd14;
  localparam logic [6:0]  ARP_BASE  = 7'd20;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ARP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_REPLY = 16'h0002;
  localparam logic [7:0]  PROTO_TCP  = 8'h06;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;
  localparam logic [7:0]  PROTO_ICMP = 8'h01;

  typedef enum logic [1:0] {
    KIND_ARP   = 2'd0,
    KIND_IPV4  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_REPLY   = 2'd1,
    OP_OTHER   = 2'd2
  } op_class_t;

  typedef enum logic [1:0] {
    PCLS_TCP   = 2'd0,
    PCLS_UDP   = 2'd1,
    PCLS_ICMP  = 2'd2,
    PCLS_OTHER = 2'd3
  } proto_class_t;

  typedef enum logic [4:0] {
    FC_DEST_MAC   = 5'd0,
    FC_SRC_MAC    = 5'd1,
    FC_KIND       = 5'd2,
    FC_ARP_OP     = 5'd3,
    FC_ARP_SMAC   = 5'd4,
    FC_ARP_SIP    = 5'd5,
    FC_ARP_TMAC   = 5'd6,
    FC_ARP_TIP    = 5'd7,
    FC_IP_VER     = 5'd8,
    FC_IP_HLEN    = 5'd9,
    FC_IP_DSCP    = 5'd10,
    FC_IP_ECN     = 5'd11,
    FC_IP_TTL     = 5'd12,
    FC_IP_PROTO   = 5'd13,
    FC_IP_CSUM    = 5'd14,
    FC_IP_CSUM_OK = 5'd15,
    FC_IP_SRC     = 5'd16,
    FC_IP_DST     = 5'd17
  } field_code_t;

  typedef struct packed {
    kind_t        kind;
    logic [47:0]  dest_mac;
    logic [47:0]  src_mac;
    op_class_t    arp_op;
    logic [47:0]  arp_smac;
    logic [47:0]  arp_tmac;
    logic [31:0]  saddr;
    logic [31:0]  taddr;
    logic [3:0]   ip_ver;
    logic [5:0]   ip_hlen;
    logic [5:0]   ip_dscp;
    logic [1:0]   ip_ecn;
    logic [7:0]   ip_ttl;
    proto_class_t ip_proto;
    logic [15:0]  ip_csum;
    logic         ip_csum_ok;
  } rec_set_t;

  typedef struct packed {
    logic     load;
    rec_set_t recs;
  } frame_t;

endpackage

FILE: hw/rtl/eaip_if.sv
// ----------------------------------------------------------------------------
// eaip interfaces
// Byte input channel and field record output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eaip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface eaip_rec_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [47:0] field_value;
  logic        last_field;

  modport source (output valid, output field_code, output field_value, output last_field,
                  input ready);
  modport sink   (input valid, input field_code, input field_value, input last_field,
                  output ready);
endinterface

FILE: hw/rtl/eaip_parser.sv
// ----------------------------------------------------------------------------
// eaip_parser
// Input register and per-byte header capture; builds the frame record set
// on the final byte and clears the captures for the next frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eaip_parser (
  input  logic              clk,
  input  logic              rst_n,
  eaip_byte_if.sink         in_ch,
  input  logic              busy,
  output eaip_pkg::frame_t  frame
);

  function automatic logic [47:0] put6(logic [47:0] r, logic [2:0] pos, logic [7:0] b);
    logic [47:0] t;
    t = r;
    t[8 * (5 - pos) +: 8] = b;
    return t;
  endfunction

  function automatic logic [31:0] put4(logic [31:0] r, logic [1:0] pos, logic [7:0] b);
    logic [31:0] t;
    t = r;
    t[8 * (3 - pos) +: 8] = b;
    return t;
  endfunction

  function automatic logic [15:0] put2(logic [15:0] r, logic pos, logic [7:0] b);
    logic [15:0] t;
    t = r;
    t[8 * (1 - pos) +: 8] = b;
    return t;
  endfunction

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  logic        s1_valid_r, s1_eof_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  logic [6:0]  off_r;
  logic [47:0] dest_r, src_r, smac_r, tmac_r;
  logic [15:0] kind_r, op_r, csum_r, sum_r;
  logic [31:0] saddr_r, taddr_r;
  logic [7:0]  ipb0_r, tos_r, ttl_r, proto_r, hold_r;

  logic [6:0]  off_nxt;
  logic [47:0] dest_nxt, src_nxt, smac_nxt, tmac_nxt;
  logic [15:0] kind_nxt, op_nxt, csum_nxt, sum_nxt, sum_fin;
  logic [31:0] saddr_nxt, taddr_nxt;
  logic [7:0]  ipb0_nxt, tos_nxt, ttl_nxt, proto_nxt, hold_nxt;
  logic [6:0]  hl_cur, rel, hdr_end, endp;
  logic        got_odd;

  assign s1_adv      = s1_valid_r && (!s1_eof_r || !busy);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eof_r  <= in_ch.end_of_frame;
    end
  end

  // apply one byte to the captures
  always_comb begin
    dest_nxt  = dest_r;
    src_nxt   = src_r;
    kind_nxt  = kind_r;
    op_nxt    = op_r;
    smac_nxt  = smac_r;
    tmac_nxt  = tmac_r;
    saddr_nxt = saddr_r;
    taddr_nxt = taddr_r;
    ipb0_nxt  = ipb0_r;
    tos_nxt   = tos_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    csum_nxt  = csum_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    off_nxt   = (off_r == eaip_pkg::OFF_MAX) ? off_r : off_r + 7'd1;

    if (off_r < 7'd6)
      dest_nxt = put6(dest_r, off_r[2:0], s1_byte_r);
    if (off_r >= 7'd6 && off_r < 7'd12)
      src_nxt = put6(src_r, 3'(off_r - 7'd6), s1_byte_r);
    if (off_r == 7'd12 || off_r == 7'd13)
      kind_nxt = put2(kind_r, off_r[0], s1_byte_r);

    if (kind_r == eaip_pkg::ETH_ARP) begin
      if (off_r >= eaip_pkg::ARP_BASE && off_r < eaip_pkg::ARP_BASE + 7'd2)
        op_nxt = put2(op_r, 1'(off_r - eaip_pkg::ARP_BASE), s1_byte_r);
      if (off_r >= eaip_pkg::ARP_BASE + 7'd2 && off_r < eaip_pkg::ARP_BASE + 7'd8)
        smac_nxt = put6(smac_r, 3'(off_r - eaip_pkg::ARP_BASE - 7'd2), s1_byte_r);
      if (off_r >= eaip_pkg::ARP_BASE + 7'd8 && off_r < eaip_pkg::ARP_BASE + 7'd12)
        saddr_nxt = put4(saddr_r, 2'(off_r - eaip_pkg::ARP_BASE - 7'd8), s1_byte_r);
      if (off_r >= eaip_pkg::ARP_BASE + 7'd12 && off_r < eaip_pkg::ARP_BASE + 7'd18)
        tmac_nxt = put6(tmac_r, 3'(off_r - eaip_pkg::ARP_BASE - 7'd12), s1_byte_r);
      if (off_r >= eaip_pkg::ARP_BASE + 7'd18 && off_r < eaip_pkg::ARP_BASE + 7'd22)
        taddr_nxt = put4(taddr_r, 2'(off_r - eaip_pkg::ARP_BASE - 7'd18), s1_byte_r);
    end else if (kind_r == eaip_pkg::ETH_IPV4) begin
      if (off_r >= eaip_pkg::IP_BASE + 7'd12 && off_r < eaip_pkg::IP_BASE + 7'd16)
        saddr_nxt = put4(saddr_r, 2'(off_r - eaip_pkg::IP_BASE - 7'd12), s1_byte_r);
      if (off_r >= eaip_pkg::IP_BASE + 7'd16 && off_r < eaip_pkg::IP_BASE + 7'd20)
        taddr_nxt = put4(taddr_r, 2'(off_r - eaip_pkg::IP_BASE - 7'd16), s1_byte_r);
    end

    if (off_r == eaip_pkg::IP_BASE)         ipb0_nxt  = s1_byte_r;
    if (off_r == eaip_pkg::IP_BASE + 7'd1)  tos_nxt   = s1_byte_r;
    if (off_r == eaip_pkg::IP_BASE + 7'd8)  ttl_nxt   = s1_byte_r;
    if (off_r == eaip_pkg::IP_BASE + 7'd9)  proto_nxt = s1_byte_r;
    if (off_r == eaip_pkg::IP_BASE + 7'd10 || off_r == eaip_pkg::IP_BASE + 7'd11)
      csum_nxt = put2(csum_r, off_r[0], s1_byte_r);

    // one's complement sum over the IPv4 header words
    hl_cur = {1'b0, ipb0_nxt[3:0], 2'b00};
    rel    = off_r - eaip_pkg::IP_BASE;
    if (off_r >= eaip_pkg::IP_BASE && rel < hl_cur) begin
      if (!rel[0])
        hold_nxt = s1_byte_r;
      else
        sum_nxt = ones_add(sum_r, {hold_r, s1_byte_r});
    end

    // close a header word cut short by the end of frame
    hdr_end = eaip_pkg::IP_BASE + hl_cur;
    endp    = (off_nxt < hdr_end) ? off_nxt : hdr_end;
    got_odd = (off_nxt > eaip_pkg::IP_BASE) && endp[0];
    sum_fin = got_odd ? ones_add(sum_nxt, {hold_nxt, 8'h00}) : sum_nxt;
  end

  always_comb begin
    frame.load          = s1_adv && s1_eof_r;
    frame.recs.dest_mac = dest_nxt;
    frame.recs.src_mac  = src_nxt;
    if (kind_nxt == eaip_pkg::ETH_ARP)
      frame.recs.kind = eaip_pkg::KIND_ARP;
    else if (kind_nxt == eaip_pkg::ETH_IPV4)
      frame.recs.kind = eaip_pkg::KIND_IPV4;
    else
      frame.recs.kind = eaip_pkg::KIND_OTHER;
    if (op_nxt == eaip_pkg::ARP_REQ)
      frame.recs.arp_op = eaip_pkg::OP_REQUEST;
    else if (op_nxt == eaip_pkg::ARP_REPLY)
      frame.recs.arp_op = eaip_pkg::OP_REPLY;
    else
      frame.recs.arp_op = eaip_pkg::OP_OTHER;
    frame.recs.arp_smac = smac_nxt;
    frame.recs.arp_tmac = tmac_nxt;
    frame.recs.saddr    = saddr_nxt;
    frame.recs.taddr    = taddr_nxt;
    frame.recs.ip_ver   = ipb0_nxt[7:4];
    frame.recs.ip_hlen  = {ipb0_nxt[3:0], 2'b00};
    frame.recs.ip_dscp  = tos_nxt[7:2];
    frame.recs.ip_ecn   = tos_nxt[1:0];
    frame.recs.ip_ttl   = ttl_nxt;
    if (proto_nxt == eaip_pkg::PROTO_TCP)
      frame.recs.ip_proto = eaip_pkg::PCLS_TCP;
    else if (proto_nxt == eaip_pkg::PROTO_UDP)
      frame.recs.ip_proto = eaip_pkg::PCLS_UDP;
    else if (proto_nxt == eaip_pkg::PROTO_ICMP)
      frame.recs.ip_proto = eaip_pkg::PCLS_ICMP;
    else
      frame.recs.ip_proto = eaip_pkg::PCLS_OTHER;
    frame.recs.ip_csum    = csum_nxt;
    frame.recs.ip_csum_ok = (sum_fin == 16'hFFFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_eof_r)) begin
      off_r   <= '0;
      dest_r  <= '0;
      src_r   <= '0;
      kind_r  <= '0;
      op_r    <= '0;
      smac_r  <= '0;
      tmac_r  <= '0;
      saddr_r <= '0;
      taddr_r <= '0;
      ipb0_r  <= '0;
      tos_r   <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
      csum_r  <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
    end else if (s1_adv) begin
      off_r   <= off_nxt;
      dest_r  <= dest_nxt;
      src_r   <= src_nxt;
      kind_r  <= kind_nxt;
      op_r    <= op_nxt;
      smac_r  <= smac_nxt;
      tmac_r  <= tmac_nxt;
      saddr_r <= saddr_nxt;
      taddr_r <= taddr_nxt;
      ipb0_r  <= ipb0_nxt;
      tos_r   <= tos_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      csum_r  <= csum_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

FILE: hw/rtl/eaip_emitter.sv
// ----------------------------------------------------------------------------
// eaip_emitter
// Holds one frame's record set and sends its field records in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eaip_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  eaip_pkg::frame_t  frame,
  output logic              busy,
  eaip_rec_if.source        out_ch
);

  eaip_pkg::rec_set_t    recs_r;
  logic                  valid_r;
  eaip_pkg::field_code_t code_r, code_nxt;
  logic                  last;
  logic                  fire;

  assign busy         = valid_r;
  assign fire         = out_ch.valid && out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.field_code = code_r;
  assign out_ch.last_field = last;

  always_comb begin
    case (recs_r.kind)
      eaip_pkg::KIND_ARP:  last = (code_r == eaip_pkg::FC_ARP_TIP);
      eaip_pkg::KIND_IPV4: last = (code_r == eaip_pkg::FC_IP_DST);
      default:             last = (code_r == eaip_pkg::FC_KIND);
    endcase
    if (code_r == eaip_pkg::FC_KIND && recs_r.kind == eaip_pkg::KIND_IPV4)
      code_nxt = eaip_pkg::FC_IP_VER;
    else
      code_nxt = eaip_pkg::field_code_t'(code_r + 5'd1);
  end

  always_comb begin
    case (code_r)
      eaip_pkg::FC_DEST_MAC:   out_ch.field_value = recs_r.dest_mac;
      eaip_pkg::FC_SRC_MAC:    out_ch.field_value = recs_r.src_mac;
      eaip_pkg::FC_KIND:       out_ch.field_value = 48'(recs_r.kind);
      eaip_pkg::FC_ARP_OP:     out_ch.field_value = 48'(recs_r.arp_op);
      eaip_pkg::FC_ARP_SMAC:   out_ch.field_value = recs_r.arp_smac;
      eaip_pkg::FC_ARP_SIP:    out_ch.field_value = 48'(recs_r.saddr);
      eaip_pkg::FC_ARP_TMAC:   out_ch.field_value = recs_r.arp_tmac;
      eaip_pkg::FC_ARP_TIP:    out_ch.field_value = 48'(recs_r.taddr);
      eaip_pkg::FC_IP_VER:     out_ch.field_value = 48'(recs_r.ip_ver);
      eaip_pkg::FC_IP_HLEN:    out_ch.field_value = 48'(recs_r.ip_hlen);
      eaip_pkg::FC_IP_DSCP:    out_ch.field_value = 48'(recs_r.ip_dscp);
      eaip_pkg::FC_IP_ECN:     out_ch.field_value = 48'(recs_r.ip_ecn);
      eaip_pkg::FC_IP_TTL:     out_ch.field_value = 48'(recs_r.ip_ttl);
      eaip_pkg::FC_IP_PROTO:   out_ch.field_value = 48'(recs_r.ip_proto);
      eaip_pkg::FC_IP_CSUM:    out_ch.field_value = 48'(recs_r.ip_csum);
      eaip_pkg::FC_IP_CSUM_OK: out_ch.field_value = 48'(recs_r.ip_csum_ok);
      eaip_pkg::FC_IP_SRC:     out_ch.field_value = 48'(recs_r.saddr);
      eaip_pkg::FC_IP_DST:     out_ch.field_value = 48'(recs_r.taddr);
      default:                 out_ch.field_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      code_r  <= eaip_pkg::FC_DEST_MAC;
    end else if (frame.load) begin
      valid_r <= 1'b1;
      code_r  <= eaip_pkg::FC_DEST_MAC;
    end else if (fire) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        code_r <= code_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      recs_r <= frame.recs;
    end
  end

endmodule

FILE: hw/rtl/ethernet_arp_ipv4_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_arp_ipv4_header_parser
// Takes a frame one byte per transaction and returns its header fields as
// a run of field records closed by last_field. The final byte of a frame
// loads a single record-set register, from which 3 (other kinds), 8 (ARP)
// or 13 (IPv4) records go out at one per cycle while out_ch.ready is high;
// the next frame's bytes keep flowing meanwhile, but its final byte waits
// in the input register until the previous run has drained, and the
// record-set register goes idle between runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_arp_ipv4_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  eaip_byte_if.sink   in_ch,
  eaip_rec_if.source  out_ch
);

  eaip_pkg::frame_t frame;
  logic             busy;

  eaip_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .busy  (busy),
    .frame (frame)
  );

  eaip_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (frame),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule

FILE: hw/rtl/eaip_checker.sv
// ----------------------------------------------------------------------------
// eaip_checker
// Port-level checks on the record run of the header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ethernet_arp_ipv4_header_parser_macros.svh"

module eaip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_field_code,
  input logic       out_last_field
);

  logic out_fire;
  logic start_code;
  logic end_code;

  assign out_fire   = out_valid && out_ready;
  assign start_code = (out_field_code == eaip_pkg::FC_DEST_MAC);
  assign end_code   = (out_field_code == eaip_pkg::FC_KIND) ||
                      (out_field_code == eaip_pkg::FC_ARP_TIP) ||
                      (out_field_code == eaip_pkg::FC_IP_DST);

  `EAIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `EAIP_ASSERT_NEXT(a_run_gap, clk, rst_n, out_fire && out_last_field, !out_valid)
  `EAIP_ASSERT_NEXT(a_run_cont, clk, rst_n, out_fire && !out_last_field, out_valid)
  `EAIP_ASSERT(a_run_start, clk, rst_n, $rose(out_valid) |-> start_code)
  `EAIP_ASSERT(a_last_code, clk, rst_n, (out_valid && out_last_field) |-> end_code)

endmodule

bind ethernet_arp_ipv4_header_parser eaip_checker u_eaip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_field_code (out_ch.field_code),
  .out_last_field (out_ch.last_field)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: header parser regression
// Sends Ethernet frames byte by byte (ARP, IPv4, other kinds, short, over-long
// and malformed), keeps a byte-level field predictor of the parser, and checks
// every returned field record in order against it under random idling on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import eaip_pkg::*;

  localparam int LIMIT          = 1000000;
  localparam int RAND_BYTES     = 90;
  localparam int LONG_HOLD_AT   = 200;
  localparam int LONG_HOLD_LEN  = 300;
  localparam int TAIL_CYCLES    = 30;

  typedef struct {
    logic [7:0]  data;
    logic        eof;
    bit          drain;
    int unsigned gap;
  } byte_item_t;

  typedef struct {
    field_code_t code;
    logic [47:0] value;
    logic        last;
  } field_rec_t;

  logic clk;
  logic rst_n;

  eaip_byte_if in_if();
  eaip_rec_if  out_if();

  ethernet_arp_ipv4_header_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  byte_item_t  pending[$];
  field_rec_t  expected_fields[$];
  logic [7:0]  frm[$];

  int unsigned wait_cnt;
  int          hold_left;
  int          calm_left;
  int          pick;
  int          cycle_count;
  int          errors;
  bit          quiet;
  byte_item_t  cur;
  field_rec_t  want;

  int frames_arp, frames_ip, frames_other, good_csum, records_checked, bytes_accepted;

  // parser state as seen from the wire
  logic [6:0]  hdr_off;
  logic [47:0] dst_mac, src_mac, arp_smac, arp_tmac;
  logic [15:0] eth_type, arp_op, csum_stored, sum_acc;
  logic [31:0] saddr, taddr;
  logic [7:0]  ver_ihl, tos, ttl, proto, hold_byte;
  int          run_left;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_capture();
    hdr_off = '0; dst_mac = '0; src_mac = '0; eth_type = '0; arp_op = '0;
    arp_smac = '0; arp_tmac = '0; saddr = '0; taddr = '0; ver_ihl = '0;
    tos = '0; ttl = '0; proto = '0; csum_stored = '0; sum_acc = '0; hold_byte = '0;
  endtask

  task automatic add_field(field_code_t c, logic [47:0] v);
    field_rec_t r;
    r.code  = c;
    r.value = v;
    r.last  = (run_left == 1);
    expected_fields.push_back(r);
    run_left--;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    int o, a, h, hl, got, endp;
    logic [15:0] sum;
    kind_t k;
    op_class_t oc;
    proto_class_t pc;
    o = int'(hdr_off);
    a = o - int'(ARP_BASE);
    h = o - int'(IP_BASE);
    if (o < 6) dst_mac[8*(5-o) +: 8] = b;
    else if (o < 12) src_mac[8*(11-o) +: 8] = b;
    else if (o < 14) eth_type[8*(13-o) +: 8] = b;
    if (eth_type == ETH_ARP) begin
      if (a >= 0 && a < 2) arp_op[8*(1-a) +: 8] = b;
      else if (a >= 2 && a < 8) arp_smac[8*(7-a) +: 8] = b;
      else if (a >= 8 && a < 12) saddr[8*(11-a) +: 8] = b;
      else if (a >= 12 && a < 18) arp_tmac[8*(17-a) +: 8] = b;
      else if (a >= 18 && a < 22) taddr[8*(21-a) +: 8] = b;
    end else if (eth_type == ETH_IPV4) begin
      if (h >= 12 && h < 16) saddr[8*(15-h) +: 8] = b;
      else if (h >= 16 && h < 20) taddr[8*(19-h) +: 8] = b;
    end
    case (h)
      0:  ver_ihl = b;
      1:  tos = b;
      8:  ttl = b;
      9:  proto = b;
      10: csum_stored[15:8] = b;
      11: csum_stored[7:0] = b;
      default: ;
    endcase
    hl = int'(ver_ihl[3:0]) * 4;
    if (h >= 0 && h < hl) begin
      if (h % 2 == 0) hold_byte = b;
      else sum_acc = ones_add(sum_acc, {hold_byte, b});
    end
    if (hdr_off < OFF_MAX) hdr_off = hdr_off + 7'd1;
    if (eof) begin
      if (eth_type == ETH_ARP) k = KIND_ARP;
      else if (eth_type == ETH_IPV4) k = KIND_IPV4;
      else k = KIND_OTHER;
      run_left = (k == KIND_ARP) ? 8 : ((k == KIND_IPV4) ? 13 : 3);
      add_field(FC_DEST_MAC, dst_mac);
      add_field(FC_SRC_MAC, src_mac);
      add_field(FC_KIND, {46'd0, k});
      if (k == KIND_ARP) begin
        frames_arp++;
        if (arp_op == ARP_REQ) oc = OP_REQUEST;
        else if (arp_op == ARP_REPLY) oc = OP_REPLY;
        else oc = OP_OTHER;
        add_field(FC_ARP_OP, {46'd0, oc});
        add_field(FC_ARP_SMAC, arp_smac);
        add_field(FC_ARP_SIP, {16'd0, saddr});
        add_field(FC_ARP_TMAC, arp_tmac);
        add_field(FC_ARP_TIP, {16'd0, taddr});
      end else if (k == KIND_IPV4) begin
        frames_ip++;
        got = 0;
        sum = sum_acc;
        if (int'(hdr_off) > int'(IP_BASE)) begin
          endp = (int'(hdr_off) < int'(IP_BASE) + hl) ? int'(hdr_off) : int'(IP_BASE) + hl;
          got = endp - int'(IP_BASE);
        end
        if (got % 2 == 1) sum = ones_add(sum, {hold_byte, 8'h00});
        if (proto == PROTO_TCP) pc = PCLS_TCP;
        else if (proto == PROTO_UDP) pc = PCLS_UDP;
        else if (proto == PROTO_ICMP) pc = PCLS_ICMP;
        else pc = PCLS_OTHER;
        if (~sum == 16'd0) good_csum++;
        add_field(FC_IP_VER, {44'd0, ver_ihl[7:4]});
        add_field(FC_IP_HLEN, 48'(hl));
        add_field(FC_IP_DSCP, {42'd0, tos[7:2]});
        add_field(FC_IP_ECN, {46'd0, tos[1:0]});
        add_field(FC_IP_TTL, {40'd0, ttl});
        add_field(FC_IP_PROTO, {46'd0, pc});
        add_field(FC_IP_CSUM, {32'd0, csum_stored});
        add_field(FC_IP_CSUM_OK, {47'd0, (~sum == 16'd0)});
        add_field(FC_IP_SRC, {16'd0, saddr});
        add_field(FC_IP_DST, {16'd0, taddr});
      end else begin
        frames_other++;
      end
      clear_capture();
    end
  endtask

  // ---------------- stimulus construction ----------------

  function automatic int unsigned rand_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_random(int n);
    repeat (n) frm.push_back(8'($urandom));
  endtask

  task automatic start_frame(logic [15:0] etype);
    frm.delete();
    put_random(12);
    frm.push_back(etype[15:8]);
    frm.push_back(etype[7:0]);
  endtask

  task automatic push_drain();
    byte_item_t it;
    it.data  = '0;
    it.eof   = 1'b0;
    it.drain = 1'b1;
    it.gap   = 0;
    pending.push_back(it);
  endtask

  task automatic send_frame(int len, bit calm);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data  = frm[i];
      it.eof   = (i == len - 1);
      it.drain = 1'b0;
      it.gap   = rand_gap(calm);
      pending.push_back(it);
    end
  endtask

  task automatic build_arp(int pad);
    logic [15:0] op;
    int r;
    start_frame(ETH_ARP);
    put_random(6);
    r = $urandom_range(0, 2);
    op = (r == 0) ? ARP_REQ : ((r == 1) ? ARP_REPLY : 16'($urandom));
    frm.push_back(op[15:8]);
    frm.push_back(op[7:0]);
    put_random(20 + pad);
  endtask

  task automatic build_ipv4(logic [3:0] ver, logic [3:0] ihl, int pad, bit good);
    logic [15:0] s;
    int hl, r;
    start_frame(ETH_IPV4);
    frm.push_back({ver, ihl});
    put_random(7);
    r = $urandom_range(0, 4);
    frm.push_back(8'($urandom));
    case (r)
      0: frm.push_back(PROTO_TCP);
      1: frm.push_back(PROTO_UDP);
      2: frm.push_back(PROTO_ICMP);
      default: frm.push_back(8'($urandom));
    endcase
    if (good) begin
      frm.push_back(8'h00);
      frm.push_back(8'h00);
    end else begin
      put_random(2);
    end
    put_random(8);
    hl = int'(ihl) * 4;
    if (hl > 20) put_random(hl - 20);
    if (good) begin
      s = '0;
      for (int i = 0; i < hl; i += 2) s = ones_add(s, {frm[14+i], frm[15+i]});
      s = ~s;
      frm[24] = s[15:8];
      frm[25] = s[7:0];
    end
    put_random(pad);
  endtask

  // ---------------- clock, reset, end of run ----------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Timeout after %0d cycles", LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int rand_bytes, len, r, nframes;
    logic [3:0] ihl;
    bit calm;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_frame = 1'b0;
    out_if.ready = 1'b0;
    cycle_count = 0;
    errors = 0;
    quiet = 1'b1;
    clear_capture();

    // single-byte frames at both data extremes, then IPv4 with zero header length
    frm = '{8'hFF};
    send_frame(1, 1'b0);
    frm = '{8'h00};
    send_frame(1, 1'b0);
    frm.delete();
    repeat (6) frm.push_back(8'hFF);
    repeat (6) frm.push_back(8'h00);
    frm.push_back(ETH_IPV4[15:8]);
    frm.push_back(ETH_IPV4[7:0]);
    frm.push_back(8'h40);
    send_frame(frm.size(), 1'b0);
    push_drain();

    // over-long frame: the offset counter saturates
    build_ipv4(4'h4, 4'h5, 100, 1'b1);
    send_frame(frm.size(), 1'b1);

    rand_bytes = 0;
    nframes = 0;
    while (rand_bytes < RAND_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 4) begin
        ihl = ($urandom_range(0, 9) < 7) ? 4'h5 : 4'($urandom_range(6, 15));
        build_ipv4(($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4, ihl,
                   $urandom_range(0, 8), $urandom_range(0, 3) != 0);
      end else if (r < 7) begin
        build_arp($urandom_range(0, 6));
      end else if (r == 7) begin
        start_frame(16'($urandom));
        put_random($urandom_range(0, 16));
      end else if (r == 8) begin
        frm.delete();
        put_random($urandom_range(1, 20));
      end else begin
        build_ipv4(4'($urandom), 4'($urandom_range(0, 4)), $urandom_range(0, 10), 1'b0);
      end
      len = frm.size();
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, frm.size());
      send_frame(len, calm);
      rand_bytes += len;
      nframes++;
      if (nframes == 2) push_drain();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending.size() != 0 || in_if.valid);
    while (expected_fields.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes: %0d ARP, %0d IPv4 (%0d with a good checksum), %0d other frames",
             bytes_accepted, frames_arp, frames_ip, good_csum, frames_other);
    $display("Checked %0d field records; %0d mismatches", records_checked, errors);
    if (errors == 0 && expected_fields.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------- byte driver ----------------

  always @(negedge clk) begin
    quiet <= (expected_fields.size() == 0);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
      in_if.end_of_frame <= 1'b0;
      wait_cnt <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.data_byte, in_if.end_of_frame);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (pending[0].drain) begin
          in_if.valid <= 1'b0;
          if (!in_if.valid && quiet) void'(pending.pop_front());
        end else if (wait_cnt < pending[0].gap) begin
          in_if.valid <= 1'b0;
          wait_cnt <= wait_cnt + 1;
        end else begin
          cur = pending.pop_front();
          in_if.valid <= 1'b1;
          in_if.data_byte <= cur.data;
          in_if.end_of_frame <= cur.eof;
          wait_cnt <= 0;
        end
      end
    end
  end

  // ---------------- record receiver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      calm_left <= 0;
    end else if (cycle_count == LONG_HOLD_AT) begin
      out_if.ready <= 1'b0;
      hold_left <= LONG_HOLD_LEN;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (calm_left > 0) begin
        calm_left <= calm_left - 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) calm_left <= 60;
        else if (pick < 23) hold_left <= $urandom_range(1, 3);
        else if (pick < 26) hold_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected record code=%0d value=%h last=%b", $time,
                 out_if.field_code, out_if.field_value, out_if.last_field);
        errors++;
      end else begin
        want = expected_fields.pop_front();
        records_checked++;
        if (out_if.field_code !== want.code) begin
          $display("%0t: field_code expected %0d got %0d", $time, want.code,
                   out_if.field_code);
          errors++;
        end
        if (out_if.field_value !== want.value) begin
          $display("%0t: field_value (code %0d) expected %h got %h", $time, want.code,
                   want.value, out_if.field_value);
          errors++;
        end
        if (out_if.last_field !== want.last) begin
          $display("%0t: last_field (code %0d) expected %b got %b", $time, want.code,
                   want.last, out_if.last_field);
          errors++;
        end
      end
    end
  end

endmodule
